@@ rtl/core/gsd_pkg.sv @@
`timescale 1ns / 1ps

package gsd_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 10;

  localparam int unsigned POS_W    = 8;
  localparam int unsigned LANES    = 4;
  localparam int unsigned SAMPLE_W = POS_W * LANES;
  localparam int unsigned WIDTH_W  = 18;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Action codes carried on in_tuser
  localparam logic [ACTION_W-1:0] ACT_GOAL    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SAMPLE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PREEMPT = 2'd2;

  // Event codes carried on out_tuser
  localparam logic [EVENT_W-1:0] EV_OPEN    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_CLOSE   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ABORT   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_SUCCESS = 3'd3;
  localparam logic [EVENT_W-1:0] EV_PREEMPT = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_WIDTH = 2'd2;

  localparam logic [THR_W-1:0]   THRESHOLD_RST   = 8'd1;
  localparam logic [WIDTH_W-1:0] OPEN_WIDTH_RST  = 18'd85000;
  localparam logic [WIDTH_W-1:0] CLOSE_WIDTH_RST = 18'd0;

  typedef struct packed {
    logic [EVENT_W-1:0] event_code;
    logic [WIDTH_W-1:0] reached_width;
  } result_t;

endpackage

@@ rtl/core/gripper_settle_detector_core.sv @@
`timescale 1ns / 1ps

// Gripper goal tracker with settle detection. One request is taken every
// clock cycle while in_tready is high; a request that produces an event
// (goal command, abort, preempt or success) is registered into the output
// stage for the out_ channel. The sample history sits in a single memory
// with one write and one registered read port; the entry oldest in the
// window is read ahead, so the compare of newest against oldest fits in the
// request cycle. A two-deep output stage lets requests keep flowing while
// one event waits; in_tready drops only while two events are pending.
// History is cleared by each goal request, so no clearing pass follows reset.
module gripper_settle_detector_core #(
  parameter int unsigned HISTORY_DEPTH = gsd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsd_pkg::WIDTH_W-1:0]   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // goal_width[17:0], act_pos_a[25:18], act_pos_b[33:26],
  // act_pos_c[41:34], act_pos_d[49:42], zero fill [55:50]
  input  logic [55:0]                   in_tdata,
  // action[1:0]
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // reached_width[17:0], zero fill [23:18]
  output logic [23:0]                   out_tdata,
  // event_code[2:0]
  output logic [2:0]                    out_tuser
);

  logic             req_acc;
  logic             push;
  gsd_pkg::result_t result;
  gsd_pkg::result_t out_data;

  assign req_acc = in_tvalid && in_tready;

  gsd_tracker #(
    .DEPTH (HISTORY_DEPTH)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .req_acc    (req_acc),
    .action     (in_tuser),
    .goal_width (in_tdata[17:0]),
    .sample     (in_tdata[49:18]),
    .push       (push),
    .result     (result)
  );

  gsd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (result),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_data)
  );

  assign out_tdata = {6'd0, out_data.reached_width};
  assign out_tuser = out_data.event_code;

endmodule

@@ rtl/core/gsd_window_mem.sv @@
`timescale 1ns / 1ps

module gsd_window_mem #(
  parameter int unsigned DEPTH = gsd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [gsd_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [gsd_pkg::SAMPLE_W-1:0] rdata
);

  logic [gsd_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [gsd_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-to-read bypass so a same-edge write is seen on the next cycle
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/gsd_tracker.sv @@
`timescale 1ns / 1ps

module gsd_tracker #(
  parameter int unsigned DEPTH = gsd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsd_pkg::WIDTH_W-1:0]   cfg_wdata,
  input  logic                          req_acc,
  input  logic [gsd_pkg::ACTION_W-1:0]  action,
  input  logic [gsd_pkg::WIDTH_W-1:0]   goal_width,
  input  logic [gsd_pkg::SAMPLE_W-1:0]  sample,
  output logic                          push,
  output gsd_pkg::result_t              result
);

  localparam logic [AW-1:0] SLOT_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(DEPTH);

  logic [gsd_pkg::THR_W-1:0]   thr_r;
  logic [gsd_pkg::WIDTH_W-1:0] open_w_r;
  logic [gsd_pkg::WIDTH_W-1:0] close_w_r;

  logic [AW-1:0]               slot_r, slot_nxt;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic                        active_r, active_nxt;
  logic [gsd_pkg::WIDTH_W-1:0] held_r, held_nxt;

  logic                         we;
  logic [AW-1:0]                raddr;
  logic [gsd_pkg::SAMPLE_W-1:0] oldest;
  logic [AW-1:0]                slot_inc;
  logic [CW-1:0]                fill_inc;
  logic                         settled;
  logic [gsd_pkg::LANES-1:0]    lane_ok;
  logic                         hit_open, hit_close;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= gsd_pkg::THRESHOLD_RST;
      open_w_r  <= gsd_pkg::OPEN_WIDTH_RST;
      close_w_r <= gsd_pkg::CLOSE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gsd_pkg::REG_THRESHOLD:   thr_r     <= cfg_wdata[gsd_pkg::THR_W-1:0];
        gsd_pkg::REG_OPEN_WIDTH:  open_w_r  <= cfg_wdata;
        gsd_pkg::REG_CLOSE_WIDTH: close_w_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gsd_window_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (slot_r),
    .wdata (sample),
    .raddr (raddr),
    .rdata (oldest)
  );

  // per-lane absolute difference against the threshold
  always_comb begin
    logic [gsd_pkg::POS_W-1:0] p, q, d;
    for (int k = 0; k < gsd_pkg::LANES; k++) begin
      p = sample[k*gsd_pkg::POS_W +: gsd_pkg::POS_W];
      q = oldest[k*gsd_pkg::POS_W +: gsd_pkg::POS_W];
      d = (p > q) ? (p - q) : (q - p);
      lane_ok[k] = (d < thr_r);
    end
  end

  assign settled   = &lane_ok;
  assign hit_open  = (goal_width == open_w_r);
  assign hit_close = (goal_width == close_w_r);
  assign slot_inc  = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign fill_inc  = (fill_r == FILL_FULL) ? FILL_FULL : fill_r + 1'b1;

  always_comb begin
    slot_nxt   = slot_r;
    fill_nxt   = fill_r;
    active_nxt = active_r;
    held_nxt   = held_r;
    we         = 1'b0;
    push       = 1'b0;
    result     = '0;
    if (req_acc) begin
      case (action)
        gsd_pkg::ACT_GOAL: begin
          slot_nxt = '0;
          fill_nxt = '0;
          push     = 1'b1;
          if (hit_open || hit_close) begin
            active_nxt = 1'b1;
            held_nxt   = goal_width;
            result.event_code = hit_open ? gsd_pkg::EV_OPEN : gsd_pkg::EV_CLOSE;
          end else begin
            active_nxt = 1'b0;
            result.event_code = gsd_pkg::EV_ABORT;
          end
        end
        gsd_pkg::ACT_PREEMPT: begin
          if (active_r) begin
            active_nxt = 1'b0;
            push       = 1'b1;
            result.event_code = gsd_pkg::EV_PREEMPT;
          end
        end
        gsd_pkg::ACT_SAMPLE: begin
          if (active_r) begin
            we       = 1'b1;
            slot_nxt = slot_inc;
            fill_nxt = fill_inc;
            // oldest was read ahead from the slot after the one now written
            if ((fill_inc == FILL_FULL) && settled) begin
              active_nxt = 1'b0;
              push       = 1'b1;
              result.event_code    = gsd_pkg::EV_SUCCESS;
              result.reached_width = held_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // keep the entry after the next write slot ready for the next request
  assign raddr = (slot_nxt == SLOT_LAST) ? '0 : slot_nxt + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      active_r <= 1'b0;
      held_r   <= '0;
    end else begin
      slot_r   <= slot_nxt;
      fill_r   <= fill_nxt;
      active_r <= active_nxt;
      held_r   <= held_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond window depth");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r < FILL_FULL) |-> (slot_r == fill_r[AW-1:0]))
    else $error("write slot out of step with fill count");

  a_goal_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (req_acc && action == gsd_pkg::ACT_GOAL) |=> (fill_r == '0 && slot_r == '0))
    else $error("goal did not clear the history");

  a_success_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (push && result.event_code == gsd_pkg::EV_SUCCESS) |=> !active_r)
    else $error("tracker still active after success");
`endif

endmodule

@@ rtl/core/gsd_out_buf.sv @@
`timescale 1ns / 1ps

module gsd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gsd_pkg::result_t push_data,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output gsd_pkg::result_t out_data
);

  logic             out_v_r;
  gsd_pkg::result_t out_d_r;
  logic             skid_v_r;
  gsd_pkg::result_t skid_d_r;
  logic             drain;

  assign drain      = !out_v_r || out_ready;
  assign can_accept = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (drain) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_d_r <= skid_v_r ? skid_d_r : push_data;
    end
    if (push && !drain) begin
      skid_d_r <= push_data;
    end
  end

endmodule
